// ----- hw/rtl/oai_pkg.sv -----
// Shared types and constants of the ordered array insert/remove block.
package oai_pkg;

  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_AT  = 2'd1,
    OP_REMOVE_VAL = 2'd2,
    OP_DUMP       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [POS_W-1:0]   position;
    logic [WORD_W-1:0]  data_word;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   element_value;
    logic [INDEX_W-1:0]  element_index;
    logic [COUNT_W-1:0]  item_count;
    logic                last;
  } out_item_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_INSERT    = 3'd1,
    CELL_SHIFT_AT  = 3'd2,
    CELL_SHIFT_HIT = 3'd3,
    CELL_ROTATE    = 3'd4
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e           cmd;
    logic [POS_W-1:0]    pos;
    logic [COUNT_W-1:0]  cnt;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/ordered_array_insert_remove.sv -----
// Top level of the ordered array: command sequencer and a chain of storage cells.
// Insert and remove at a position: result in the cycle after start, busy stays low, one item a cycle.
// Remove by value: compare in S_CMP, shift in S_HIT; the result is registered from S_HIT, busy in both states.
// Dump: one result per stored word on consecutive cycles, each registered from S_DUMP; busy while dumping.
// Reset empties the array and sets the match mask to all ones; results cannot be stalled.
module ordered_array_insert_remove #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  oai_pkg::in_item_t  in_item_i,
  output logic               result_valid_o,
  output oai_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import oai_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_HIT,
    S_DUMP
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   idx_q;
  logic [WORD_W-1:0]  mask_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic               res_valid_q;
  out_item_t          res_q;

  cell_ctl_t             ctl;
  logic [DATA_WIDTH-1:0] vals [CAPACITY];
  logic [CAPACITY:0]     hit_w;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] cnt_inc, cnt_dec;
  logic [POS_W-1:0] count_pos, pos_eff;
  logic             dump_last;

  assign accept    = start && (state_q == S_IDLE);
  assign busy      = (state_q != S_IDLE);
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign cnt_inc   = count_q + CNT_W'(1);
  assign cnt_dec   = count_q - CNT_W'(1);
  assign count_pos = POS_W'(count_q);
  assign pos_eff   = (in_item_i.position > count_pos) ? count_pos : in_item_i.position;
  assign dump_last = (CNT_W'(idx_q) == cnt_dec);

  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Command for the cell chain.
  always_comb begin
    ctl.cmd = CELL_HOLD;
    ctl.pos = in_item_i.position;
    ctl.cnt = COUNT_W'(count_q);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item_i.operation)
            OP_INSERT: begin
              if (!full) begin
                ctl.cmd = CELL_INSERT;
                ctl.pos = pos_eff;
              end
            end
            OP_REMOVE_AT: begin
              if (!empty && (in_item_i.position < count_pos)) begin
                ctl.cmd = CELL_SHIFT_AT;
              end
            end
            default: ctl.cmd = CELL_HOLD;
          endcase
        end
      end
      S_CMP:   ctl.cmd = CELL_HOLD;
      S_HIT:   ctl.cmd = CELL_SHIFT_HIT;
      S_DUMP:  ctl.cmd = CELL_ROTATE;
      default: ctl.cmd = CELL_HOLD;
    endcase
  end

  assign hit_w[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = vals[i];
    end else begin : g_mid_prev
      assign prev_w = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = vals[i];
    end else begin : g_mid_next
      assign next_w = vals[i+1];
    end

    oai_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .word_i  (DATA_WIDTH'(in_item_i.data_word)),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .head_i  (vals[0]),
      .key_i   (key_q),
      .mask_i  (DATA_WIDTH'(mask_q)),
      .hit_i   (hit_w[i]),
      .hit_o   (hit_w[i+1]),
      .value_o (vals[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      mask_q      <= '1;
      key_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_q.status        <= ST_OK;
            res_q.element_value <= '0;
            res_q.element_index <= '0;
            res_q.item_count    <= COUNT_W'(count_q);
            res_q.last          <= 1'b1;
            key_q               <= DATA_WIDTH'(in_item_i.data_word);
            unique case (in_item_i.operation)
              OP_INSERT: begin
                res_valid_q <= 1'b1;
                if (full) begin
                  res_q.status <= ST_FULL;
                end else begin
                  count_q          <= cnt_inc;
                  res_q.item_count <= COUNT_W'(cnt_inc);
                end
              end
              OP_REMOVE_AT: begin
                res_valid_q <= 1'b1;
                if (empty) begin
                  res_q.status <= ST_EMPTY;
                end else if (in_item_i.position >= count_pos) begin
                  res_q.status <= ST_RANGE;
                end else begin
                  count_q          <= cnt_dec;
                  res_q.item_count <= COUNT_W'(cnt_dec);
                end
              end
              OP_REMOVE_VAL: begin
                if (empty) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_EMPTY;
                end else begin
                  state_q <= S_CMP;
                end
              end
              OP_DUMP: begin
                if (empty) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= ST_EMPTY;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_DUMP;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_CMP: begin
          state_q <= S_HIT;
        end
        S_HIT: begin
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
          if (hit_w[CAPACITY]) begin
            count_q          <= cnt_dec;
            res_q.status     <= ST_OK;
            res_q.item_count <= COUNT_W'(cnt_dec);
          end else begin
            res_q.status <= ST_NOT_FOUND;
          end
        end
        S_DUMP: begin
          // The head cell always holds the next word while the chain rotates.
          res_valid_q         <= 1'b1;
          res_q.status        <= ST_OK;
          res_q.element_value <= WORD_W'(vals[0]);
          res_q.element_index <= INDEX_W'(idx_q);
          res_q.item_count    <= COUNT_W'(count_q);
          res_q.last          <= dump_last;
          if (dump_last) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_item_i.operation == OP_INSERT) && !full) |=> (count_q == $past(cnt_inc)))
    else $error("insert did not grow the count");

  a_dump_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |=> result_valid_o)
    else $error("dump cycle produced no result");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && !start) |=> !result_valid_o)
    else $error("result without an accepted item");

  a_cmp_to_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |=> ((state_q == S_HIT) && !result_valid_o))
    else $error("compare cycle not followed by shift cycle");

endmodule

// ----- hw/rtl/oai_cell.sv -----
// One storage cell of the ordered chain: holds a word and trades it with its neighbors.
module oai_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  oai_pkg::cell_ctl_t    ctl_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  input  logic [DATA_WIDTH-1:0] head_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [DATA_WIDTH-1:0] mask_i,
  input  logic                  hit_i,
  output logic                  hit_o,
  output logic [DATA_WIDTH-1:0] value_o
);
  import oai_pkg::*;

  localparam logic [POS_W-1:0]   MY_POS   = POS_W'(INDEX);
  localparam logic [COUNT_W-1:0] MY_CNT   = COUNT_W'(INDEX);
  localparam logic [COUNT_W-1:0] NEXT_CNT = COUNT_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] value_q, value_d;
  logic                  match_q, match_d;
  logic                  shift_hit;

  // A cell at or after the first match moves down by one.
  assign shift_hit = hit_i | match_q;
  assign hit_o     = shift_hit;
  assign value_o   = value_q;

  assign match_d = (MY_CNT < ctl_i.cnt) && (((value_q ^ key_i) & mask_i) == '0);

  always_comb begin
    value_d = value_q;
    unique case (ctl_i.cmd)
      CELL_HOLD: value_d = value_q;
      CELL_INSERT: begin
        if (MY_POS > ctl_i.pos) begin
          value_d = prev_i;
        end else if (MY_POS == ctl_i.pos) begin
          value_d = word_i;
        end
      end
      CELL_SHIFT_AT: begin
        if (MY_POS >= ctl_i.pos) begin
          value_d = next_i;
        end
      end
      CELL_SHIFT_HIT: begin
        if (shift_hit) begin
          value_d = next_i;
        end
      end
      CELL_ROTATE: begin
        // The last occupied cell takes the head word, the rest move down.
        if (NEXT_CNT == ctl_i.cnt) begin
          value_d = head_i;
        end else begin
          value_d = next_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

endmodule
